>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked on every rising clock edge out of reset
`define POI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// overlapping implication
`define POI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/poi_pkg.sv
package poi_pkg;

    // apb map: one register at byte address 0
    localparam int APB_AW = 3;
    localparam logic [APB_AW-3:0] REG_YAW_GAIN = '0;
    localparam logic [15:0] YAW_GAIN_RST = 16'd960;

    // cordic start vector, 1/K in Q1.30
    localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;
    localparam int ATAN_IW = 5;

    // shared multiplier operand and product widths
    localparam int MUL_AW = 42;
    localparam int MUL_BW = 19;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    // mm/s * us -> Q16.16 m, and Q16.16 rad/s * us -> binary angle
    localparam logic signed [MUL_BW-1:0] POS_SCALE = 19'sd70369;
    localparam logic signed [MUL_BW-1:0] ANG_SCALE = 19'sd174993;

    typedef struct packed {
        logic signed [15:0] cos_q;
        logic signed [15:0] sin_q;
    } sincos_t;

    typedef enum logic [16:0] {
        ST_IDLE     = 17'h00001,
        ST_VEL      = 17'h00002,
        ST_VEL_WB   = 17'h00004,
        ST_SC1_WAIT = 17'h00008,
        ST_M1       = 17'h00010,
        ST_M2       = 17'h00020,
        ST_M3       = 17'h00040,
        ST_M4       = 17'h00080,
        ST_M5       = 17'h00100,
        ST_M6       = 17'h00200,
        ST_M7       = 17'h00400,
        ST_M8       = 17'h00800,
        ST_M9       = 17'h01000,
        ST_M10      = 17'h02000,
        ST_HEAD     = 17'h04000,
        ST_SC2_WAIT = 17'h08000,
        ST_OUT      = 17'h10000
    } state_t;

    // arctangent of 2^-i as a 32-bit binary angle
    function automatic logic signed [31:0] atan_lut(input logic [ATAN_IW-1:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:    v = 32'sd536870912;
            5'd1:    v = 32'sd316933406;
            5'd2:    v = 32'sd167458907;
            5'd3:    v = 32'sd85004756;
            5'd4:    v = 32'sd42667331;
            5'd5:    v = 32'sd21354465;
            5'd6:    v = 32'sd10679838;
            5'd7:    v = 32'sd5340245;
            5'd8:    v = 32'sd2670163;
            5'd9:    v = 32'sd1335087;
            5'd10:   v = 32'sd667544;
            5'd11:   v = 32'sd333772;
            5'd12:   v = 32'sd166886;
            5'd13:   v = 32'sd83443;
            5'd14:   v = 32'sd41722;
            5'd15:   v = 32'sd20861;
            5'd16:   v = 32'sd10430;
            5'd17:   v = 32'sd5215;
            5'd18:   v = 32'sd2608;
            5'd19:   v = 32'sd1304;
            5'd20:   v = 32'sd652;
            5'd21:   v = 32'sd326;
            5'd22:   v = 32'sd163;
            5'd23:   v = 32'sd81;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    // Q1.30 -> Q1.15 with round half up and clamp
    function automatic logic signed [15:0] round_q15(input logic signed [33:0] v);
        logic signed [34:0] t;
        logic signed [15:0] r;
        t = (35'(v) + 35'sd16384) >>> 15;
        if (t > 35'sd32767)
            r = 16'sh7fff;
        else if (t < -35'sd32768)
            r = 16'sh8000;
        else
            r = t[15:0];
        return r;
    endfunction

    // negate with the most negative value clamped
    function automatic logic signed [15:0] sat_neg16(input logic signed [15:0] v);
        logic signed [15:0] r;
        if (v == 16'sh8000)
            r = 16'sh7fff;
        else
            r = -v;
        return r;
    endfunction

endpackage

>>> rtl/planar_odometry_integrator.sv
// velocity request: state updated in ST_VEL and ST_VEL_WB, no result
// tick request: result valid after the second cordic pass, once the output register is free
// one request at a time; a tick is paced by two passes through the shared cordic
// and ten issues to the shared multiplier
// reset clears pose, velocities and yaw rate to zero and yaw_gain to 960 (3.75)
`include "assert_macros.svh"

module planar_odometry_integrator #(
    parameter int CORDIC_STAGES = 16,
    parameter int POS_WIDTH     = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [63:0]                  s_tdata,   // raw_vx, raw_vy, raw_yaw, dt_us
    input  logic [0:0]                   s_tuser,   // op
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // pos_x, pos_y, heading, quat_z, quat_w, vel_x, vel_y, yaw_rate
    output logic [175:0]                 m_tdata,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [poi_pkg::APB_AW-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import poi_pkg::*;

    localparam int EXT_W = (POS_WIDTH > 32) ? POS_WIDTH : 32;

    state_t state_reg;
    state_t state_next;

    logic [15:0] yaw_gain;

    // request capture
    logic signed [15:0] nvx_in_reg;
    logic signed [15:0] vy_in_reg;
    logic signed [15:0] nyaw_in_reg;
    logic [15:0]        dt_reg;

    // architectural state
    logic signed [15:0]          body_vel_x_reg;
    logic signed [15:0]          body_vel_y_reg;
    logic signed [31:0]          turn_rate_reg;
    logic signed [POS_WIDTH-1:0] acc_x_reg;
    logic signed [POS_WIDTH-1:0] acc_y_reg;
    logic [31:0]                 acc_heading_reg;

    // tick intermediates
    sincos_t                   sc_reg;
    sincos_t                   q_reg;
    logic signed [32:0]        t_reg;
    logic signed [32:0]        rx_reg;
    logic signed [32:0]        ry_reg;
    logic signed [MUL_AW-1:0]  sx_reg;
    logic signed [MUL_AW-1:0]  sy_reg;
    logic signed [MUL_AW-1:0]  sth_reg;

    logic                     m_tvalid_reg;
    logic [175:0]             m_tdata_reg;

    logic                     in_acc;
    logic                     out_go;
    logic                     cor_start;
    logic [31:0]              cor_angle;
    logic                     cor_busy;
    logic                     cor_done;
    sincos_t                  cor_res;
    logic signed [MUL_AW-1:0] mul_a;
    logic signed [MUL_BW-1:0] mul_b;
    logic signed [MUL_PW-1:0] mul_p;
    logic [31:0]              heading_new;
    logic signed [EXT_W-1:0]  pos_x_ext;
    logic signed [EXT_W-1:0]  pos_y_ext;

    poi_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .yaw_gain (yaw_gain)
    );

    poi_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cor_start),
        .angle  (cor_angle),
        .busy   (cor_busy),
        .done   (cor_done),
        .result (cor_res)
    );

    poi_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    assign s_tready    = (state_reg == ST_IDLE);
    assign in_acc      = s_tvalid && s_tready;
    assign out_go      = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);
    assign heading_new = acc_heading_reg + mul_p[47:16];

    // first pass on the old heading, second on half the new heading
    assign cor_start = (in_acc && s_tuser[0]) || (state_reg == ST_HEAD);
    assign cor_angle = (state_reg == ST_HEAD) ? {1'b0, heading_new[31:1]} : acc_heading_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                    state_next = s_tuser[0] ? ST_SC1_WAIT : ST_VEL;
            end
            ST_VEL:      state_next = ST_VEL_WB;
            ST_VEL_WB:   state_next = ST_IDLE;
            ST_SC1_WAIT:
            begin
                if (cor_done)
                    state_next = ST_M1;
            end
            ST_M1:       state_next = ST_M2;
            ST_M2:       state_next = ST_M3;
            ST_M3:       state_next = ST_M4;
            ST_M4:       state_next = ST_M5;
            ST_M5:       state_next = ST_M6;
            ST_M6:       state_next = ST_M7;
            ST_M7:       state_next = ST_M8;
            ST_M8:       state_next = ST_M9;
            ST_M9:       state_next = ST_M10;
            ST_M10:      state_next = ST_HEAD;
            ST_HEAD:     state_next = ST_SC2_WAIT;
            ST_SC2_WAIT:
            begin
                if (cor_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_go)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // multiplier issue; each product is consumed one state later
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_VEL:
            begin
                mul_a = MUL_AW'(nyaw_in_reg);
                mul_b = {3'b000, yaw_gain};
            end
            ST_M1:
            begin
                mul_a = MUL_AW'(body_vel_x_reg);
                mul_b = MUL_BW'($signed(sc_reg.cos_q));
            end
            ST_M2:
            begin
                mul_a = MUL_AW'(body_vel_y_reg);
                mul_b = MUL_BW'($signed(sc_reg.sin_q));
            end
            ST_M3:
            begin
                mul_a = MUL_AW'(body_vel_x_reg);
                mul_b = MUL_BW'($signed(sc_reg.sin_q));
            end
            ST_M4:
            begin
                mul_a = MUL_AW'(body_vel_y_reg);
                mul_b = MUL_BW'($signed(sc_reg.cos_q));
            end
            ST_M5:
            begin
                mul_a = MUL_AW'(rx_reg);
                mul_b = {3'b000, dt_reg};
            end
            ST_M6:
            begin
                mul_a = MUL_AW'(ry_reg);
                mul_b = {3'b000, dt_reg};
            end
            ST_M7:
            begin
                mul_a = MUL_AW'(turn_rate_reg);
                mul_b = {3'b000, dt_reg};
            end
            ST_M8:
            begin
                mul_a = sx_reg;
                mul_b = POS_SCALE;
            end
            ST_M9:
            begin
                mul_a = sy_reg;
                mul_b = POS_SCALE;
            end
            ST_M10:
            begin
                mul_a = sth_reg;
                mul_b = ANG_SCALE;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            body_vel_x_reg  <= '0;
            body_vel_y_reg  <= '0;
            turn_rate_reg   <= '0;
            acc_x_reg       <= '0;
            acc_y_reg       <= '0;
            acc_heading_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_VEL:
                begin
                    body_vel_x_reg <= nvx_in_reg;
                    body_vel_y_reg <= vy_in_reg;
                end
                ST_VEL_WB: turn_rate_reg   <= mul_p[33:2];
                ST_M9:     acc_x_reg       <= acc_x_reg + POS_WIDTH'(mul_p >>> 37);
                ST_M10:    acc_y_reg       <= acc_y_reg + POS_WIDTH'(mul_p >>> 37);
                ST_HEAD:   acc_heading_reg <= heading_new;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            nvx_in_reg  <= sat_neg16(s_tdata[15:0]);
            vy_in_reg   <= s_tdata[31:16];
            nyaw_in_reg <= sat_neg16(s_tdata[47:32]);
            dt_reg      <= s_tdata[63:48];
        end
        if (state_reg == ST_SC1_WAIT && cor_done)
            sc_reg <= cor_res;
        if (state_reg == ST_SC2_WAIT && cor_done)
            q_reg <= cor_res;
        case (state_reg)
            ST_M2:   t_reg   <= mul_p[32:0];
            ST_M3:   rx_reg  <= t_reg - mul_p[32:0];
            ST_M4:   t_reg   <= mul_p[32:0];
            ST_M5:   ry_reg  <= t_reg + mul_p[32:0];
            ST_M6:   sx_reg  <= mul_p[49:8];
            ST_M7:   sy_reg  <= mul_p[49:8];
            ST_M8:   sth_reg <= mul_p[49:8];
            default: ;
        endcase
    end

    assign pos_x_ext = EXT_W'(acc_x_reg);
    assign pos_y_ext = EXT_W'(acc_y_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_go)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_go)
        begin
            // quaternion: w is the cosine, z the sine of the half heading
            m_tdata_reg <= {turn_rate_reg, body_vel_y_reg, body_vel_x_reg,
                            q_reg.cos_q, q_reg.sin_q, acc_heading_reg[31:16],
                            pos_y_ext[31:0], pos_x_ext[31:0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `POI_ASSERT_IMP(a_vel_no_result, s_tvalid && s_tready && !s_tuser[0], ##1 !$rose(m_tvalid_reg), "velocity request produced a result")
    `POI_ASSERT_IMP(a_cordic_free, cor_start, !cor_busy, "cordic restarted while busy")
    `POI_ASSERT(a_heading_update, $stable(acc_heading_reg) || ($past(state_reg) == ST_HEAD), "heading changed outside the update step")

endmodule

>>> rtl/poi_cfg.sv
module poi_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [poi_pkg::APB_AW-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output logic [15:0]                  yaw_gain
);
    import poi_pkg::*;

    logic [15:0] yaw_gain_reg;
    logic        sel_gain;
    logic        wr_en;

    assign pready   = 1'b1;
    assign sel_gain = (paddr[APB_AW-1:2] == REG_YAW_GAIN);
    assign wr_en    = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yaw_gain_reg <= YAW_GAIN_RST;
        end
        else if (wr_en && sel_gain)
        begin
            yaw_gain_reg <= pwdata[15:0];
        end
    end

    assign prdata   = sel_gain ? {16'd0, yaw_gain_reg} : 32'd0;
    assign yaw_gain = yaw_gain_reg;

endmodule

>>> rtl/poi_mul.sv
module poi_mul (
    input  logic                                clk,
    input  logic signed [poi_pkg::MUL_AW-1:0]   a,
    input  logic signed [poi_pkg::MUL_BW-1:0]   b,
    output logic signed [poi_pkg::MUL_PW-1:0]   p
);
    import poi_pkg::*;

    logic signed [MUL_PW-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= MUL_PW'(a) * MUL_PW'(b);
    end

    assign p = p_reg;

endmodule

>>> rtl/poi_cordic.sv
module poi_cordic #(
    parameter int STAGES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [31:0]       angle,
    output logic              busy,
    output logic              done,
    output poi_pkg::sincos_t  result
);
    import poi_pkg::*;

    localparam int CW = $clog2(STAGES + 1);

    logic              run_reg;
    logic              done_reg;
    logic [CW-1:0]     cnt_reg;
    logic signed [32:0] x_reg;
    logic signed [32:0] y_reg;
    logic signed [31:0] z_reg;
    logic [1:0]        quad_reg;
    sincos_t           res_reg;

    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [31:0] atan_v;
    logic               last;
    logic signed [33:0] rc;
    logic signed [33:0] rs;

    assign dx     = y_reg >>> cnt_reg;
    assign dy     = x_reg >>> cnt_reg;
    assign atan_v = atan_lut(ATAN_IW'(cnt_reg));
    assign last   = (cnt_reg == CW'(STAGES));

    // fold the first-quadrant result back into the full circle
    always_comb
    begin
        case (quad_reg)
            2'd0:
            begin
                rc = 34'(x_reg);
                rs = 34'(y_reg);
            end
            2'd1:
            begin
                rc = -34'(y_reg);
                rs = 34'(x_reg);
            end
            2'd2:
            begin
                rc = -34'(x_reg);
                rs = -34'(y_reg);
            end
            default:
            begin
                rc = 34'(y_reg);
                rs = -34'(x_reg);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                if (last)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= CORDIC_X0;
            y_reg    <= '0;
            z_reg    <= {2'b00, angle[29:0]};
            quad_reg <= angle[31:30];
        end
        else if (run_reg && !last)
        begin
            if (!z_reg[31])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_v;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_v;
            end
        end
        if (run_reg && last)
        begin
            res_reg.cos_q <= round_q15(rc);
            res_reg.sin_q <= round_q15(rs);
        end
    end

    assign busy   = run_reg;
    assign done   = done_reg;
    assign result = res_reg;

endmodule
